FILE: hw/rtl/utf8_decoder_bmp_stream_macros.svh
// Assertion macros used by the decoder's checker file.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef UTF8_DECODER_BMP_STREAM_MACROS_SVH
`define UTF8_DECODER_BMP_STREAM_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define U8DEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define U8DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/u8dec_pkg.sv
// Types, constants and helper functions for the UTF-8 BMP stream decoder.
// Used by the top level and its port checker; depends on nothing.
package u8dec_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 16;
    localparam int CNT_W    = 12;
    localparam int WIDE_CP_W = 21;
    localparam int M_DATA_W = 32;
    localparam int NUM_SLOTS = 3;

    localparam logic [CNT_W-1:0] CHAR_LIMIT_RST = 12'd255;

    // Result kinds, carried on m_tuser.
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Sequence lengths announced by a lead byte.
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             kind;
        logic [CNT_W-1:0] char_count;
        logic             last;
    } res_t;

    function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] c);
        logic [2:0] len;
        len = LEN_NONE;
        if (c < 8'h80)                 len = LEN_ONE;
        else if ((c & 8'hE0) == 8'hC0) len = LEN_TWO;
        else if ((c & 8'hF0) == 8'hE0) len = LEN_THREE;
        else if ((c & 8'hF8) == 8'hF0) len = LEN_FOUR;
        return len;
    endfunction

endpackage

FILE: hw/rtl/utf8_decoder_bmp_stream.sv
// Top level of the UTF-8 to BMP code point stream decoder.
// Depends on u8dec_pkg for result types, kind codes and lead decoding.
//
// Channel  Dir  tdata (low bit up)                 tuser  tlast
// s_       in   byte_value[7:0]                    -      end_of_text
// m_       out  code_point[15:0], char_count[27:16] kind   last result of a byte
// cfg_wr_  in   char_limit[11:0] on cfg_wr_data    -      -     (written on cfg_wr_en)
//
// One byte is taken per cycle while s_tready is high. A byte that yields k results
// (at most three, only at end of text) holds s_tready low while the result bank
// drains one beat a cycle when m_tready is high; a byte with no result does not.
// The bound is the single three-entry result bank between decode and m_.
// Reset (aresetn low at a clock edge) empties the bank, clears the held bytes
// and the count, and restores char_limit to 255. A stalled m_ side holds the
// current beat; a new byte is still taken in the cycle the final beat leaves.
module utf8_decoder_bmp_stream
    import u8dec_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // byte_value[7:0]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // code_point[15:0], char_count[27:16], zero
    output logic                m_tuser,   // kind[0]
    output logic                m_tlast
);

    // Configuration and decode state.
    logic [CNT_W-1:0]  char_limit_reg;
    logic [BYTE_W-1:0] held_reg [NUM_SLOTS];
    logic [1:0]        held_cnt_reg;
    logic [CNT_W-1:0]  emit_cnt_reg;

    // Result bank: entry 0 is the beat on m_.
    res_t              ent_reg [NUM_SLOTS];
    logic [1:0]        rem_reg;

    // Decode outputs.
    logic [BYTE_W-1:0] held_next [NUM_SLOTS];
    logic [1:0]        held_cnt_next;
    logic [CNT_W-1:0]  emit_cnt_next;
    res_t              ent_next [NUM_SLOTS];
    logic [1:0]        rem_next;

    logic [BYTE_W-1:0] byte_in;
    logic              end_txt;
    logic [2:0]        lead_len;
    logic [2:0]        byte_len;
    logic [WIDE_CP_W-1:0] wide_cp;
    logic [BYTE_W-1:0] p_held [NUM_SLOTS];
    logic [1:0]        p_cnt;
    logic              c0_vld;
    logic [CP_W-1:0]   c0_cp;
    logic              x_vld, y_vld, x_emit, y_emit;
    logic [CP_W-1:0]   x_cp, y_cp;
    logic [CNT_W-1:0]  cnt_x, cnt_y;
    logic              slot_vld [NUM_SLOTS];
    res_t              slot_res [NUM_SLOTS];

    logic s_fire, m_fire;

    assign m_tvalid = (rem_reg != 2'd0);
    assign m_fire   = m_tvalid & m_tready;
    // Take a byte when the bank is empty or its final beat leaves now.
    assign s_tready = (rem_reg == 2'd0) | ((rem_reg == 2'd1) & m_tready);
    assign s_fire   = s_tvalid & s_tready;

    assign m_tdata = {{(M_DATA_W - CNT_W - CP_W){1'b0}},
                      ent_reg[0].char_count, ent_reg[0].code_point};
    assign m_tuser = ent_reg[0].kind;
    assign m_tlast = ent_reg[0].last;

    assign byte_in  = s_tdata;
    assign end_txt  = s_tlast | (byte_in == 8'h00);
    assign lead_len = seq_len(held_reg[0]);
    assign byte_len = seq_len(byte_in);

    // Assemble the wide value a completing byte would give.
    always_comb begin
        case (lead_len)
            LEN_TWO:   wide_cp = {10'd0, held_reg[0][4:0], byte_in[5:0]};
            LEN_THREE: wide_cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], byte_in[5:0]};
            LEN_FOUR:  wide_cp = {held_reg[0][2:0], held_reg[1][5:0],
                                  held_reg[2][5:0], byte_in[5:0]};
            default:   wide_cp = '0;
        endcase
    end

    // Feed the byte into the held sequence.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) p_held[i] = held_reg[i];
        p_cnt  = held_cnt_reg;
        c0_vld = 1'b0;
        c0_cp  = '0;
        if (byte_in != 8'h00) begin
            if (held_cnt_reg == 2'd0) begin
                if (byte_len == LEN_ONE) begin
                    c0_vld = 1'b1;
                    c0_cp  = {8'h00, byte_in};
                end else if (byte_len != LEN_NONE) begin
                    p_held[0] = byte_in;
                    p_cnt     = 2'd1;
                end
            end else if ({1'b0, held_cnt_reg} < (lead_len - 3'd1)) begin
                if (held_cnt_reg == 2'd1) p_held[1] = byte_in;
                else                      p_held[2] = byte_in;
                p_cnt = held_cnt_reg + 2'd1;
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) p_held[i] = '0;
                p_cnt  = 2'd0;
                // Drop anything beyond the BMP.
                c0_vld = (wide_cp[WIDE_CP_W-1:CP_W] == '0);
                c0_cp  = wide_cp[CP_W-1:0];
            end
        end
    end

    // Candidate characters: the fed byte's result, or what draining leaves.
    always_comb begin
        x_vld = 1'b0;
        x_cp  = '0;
        y_vld = 1'b0;
        y_cp  = '0;
        if (c0_vld) begin
            x_vld = 1'b1;
            x_cp  = c0_cp;
        end else if (end_txt) begin
            // Lead is lost; the held continuations are fed again as leads.
            if (p_cnt == 2'd2) begin
                x_vld = ~p_held[1][7];
                x_cp  = {8'h00, p_held[1]};
            end else if (p_cnt == 2'd3) begin
                if (seq_len(p_held[1]) == LEN_TWO) begin
                    x_vld = 1'b1;
                    x_cp  = {5'd0, p_held[1][4:0], p_held[2][5:0]};
                end else begin
                    x_vld = ~p_held[1][7];
                    x_cp  = {8'h00, p_held[1]};
                    y_vld = ~p_held[2][7];
                    y_cp  = {8'h00, p_held[2]};
                end
            end
        end
    end

    // Apply the character limit in emission order.
    always_comb begin
        x_emit = x_vld & (emit_cnt_reg < char_limit_reg);
        cnt_x  = emit_cnt_reg + {{(CNT_W-1){1'b0}}, x_emit};
        y_emit = y_vld & (cnt_x < char_limit_reg);
        cnt_y  = cnt_x + {{(CNT_W-1){1'b0}}, y_emit};
    end

    // Build the result slots and pack them into the bank.
    always_comb begin
        logic [1:0] n;
        slot_vld[0] = x_emit;
        slot_vld[1] = y_emit;
        slot_vld[2] = end_txt;
        slot_res[0] = '{code_point: x_cp, kind: KIND_CHAR, char_count: cnt_x,
                        last: ~y_emit & ~end_txt};
        slot_res[1] = '{code_point: y_cp, kind: KIND_CHAR, char_count: cnt_y,
                        last: ~end_txt};
        slot_res[2] = '{code_point: '0, kind: KIND_SUMMARY, char_count: cnt_y,
                        last: 1'b1};
        n = 2'd0;
        for (int i = 0; i < NUM_SLOTS; i++) ent_next[i] = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot_vld[k]) begin
                ent_next[n] = slot_res[k];
                n = n + 2'd1;
            end
        end
        rem_next = n;
    end

    // End of text clears the held bytes and the count; otherwise keep the fed state.
    always_comb begin
        if (end_txt) begin
            for (int i = 0; i < NUM_SLOTS; i++) held_next[i] = '0;
            held_cnt_next = 2'd0;
            emit_cnt_next = '0;
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) held_next[i] = p_held[i];
            held_cnt_next = p_cnt;
            emit_cnt_next = cnt_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_limit_reg <= CHAR_LIMIT_RST;
        end else if (cfg_wr_en) begin
            char_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) held_reg[i] <= '0;
            held_cnt_reg <= 2'd0;
            emit_cnt_reg <= '0;
        end else if (s_fire) begin
            for (int i = 0; i < NUM_SLOTS; i++) held_reg[i] <= held_next[i];
            held_cnt_reg <= held_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else if (s_fire) begin
            rem_reg <= rem_next;
        end else if (m_fire) begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    // Bank payload: load on a new byte, else advance by one beat.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < NUM_SLOTS; i++) ent_reg[i] <= ent_next[i];
        end else if (m_fire) begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

endmodule

FILE: hw/rtl/u8dec_checker.sv
// Port checker for the UTF-8 BMP stream decoder, bound to the top level.
// Depends on u8dec_pkg and utf8_decoder_bmp_stream_macros.svh.
`include "utf8_decoder_bmp_stream_macros.svh"

module u8dec_checker
    import u8dec_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    logic                sum_beat;
    logic                char_beat;
    logic                m_stall;
    logic [CP_W-1:0]     beat_cp;
    logic [CNT_W-1:0]    beat_cnt;
    logic [M_DATA_W+1:0] m_beat;

    assign sum_beat  = m_tvalid && (m_tuser == KIND_SUMMARY);
    assign char_beat = m_tvalid && (m_tuser == KIND_CHAR);
    assign m_stall   = m_tvalid && !m_tready;
    assign beat_cp   = m_tdata[CP_W-1:0];
    assign beat_cnt  = m_tdata[CP_W+CNT_W-1:CP_W];
    assign m_beat    = {m_tlast, m_tuser, m_tdata};

    // A summary closes the run of beats for its byte and carries no character.
    `U8DEC_ASSERT_NOW(a_summary_last, sum_beat, m_tlast, "summary beat without tlast")
    `U8DEC_ASSERT_NOW(a_summary_zero_cp, sum_beat, beat_cp == '0, "summary with a code point")

    // A character beat counts itself, so its count is never zero.
    `U8DEC_ASSERT_NOW(a_char_counted, char_beat, beat_cnt != '0, "character with zero count")

    // A stalled result beat holds.
    `U8DEC_ASSERT_NEXT(a_m_hold, m_stall, m_tvalid && $stable(m_beat), "stalled beat changed")

endmodule

bind utf8_decoder_bmp_stream u8dec_checker u_u8dec_checker (.*);
